### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the controller of the running-max stack.
// ----------------------------------------------------------------------------
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every enabled clock edge.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property violated");

// The expression must never be true at an enabled clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

### src/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants of the running-max stack: operation and status
// codes, and the command and flag bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swrm_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    load_top;
    logic    out_load;
    status_e status;
  } cmd_t;

  // Stack occupancy flags from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } flags_t;

endpackage

`default_nettype wire

### src/swrm_ctrl.sv
// ----------------------------------------------------------------------------
// swrm_ctrl
// Controller of the running-max stack: accepts words, sequences pushes and
// pops, decides the status code and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swrm_ctrl
  import swrm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   func_i,
  input  logic   out_stall_i,
  input  flags_t flags_i,
  output logic   in_stall_o,
  output logic   out_valid_o,
  output cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RESP
  } state_e;

  state_e  state_q;
  status_e status_q;
  logic    out_valid_q;
  logic    accept;
  logic    out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.push     = accept && (func_i == FUNC_PUSH) && !flags_i.full;
    cmd_o.pop      = accept && (func_i == FUNC_POP) && !flags_i.empty;
    cmd_o.load_top = (state_q == S_LOAD);
    cmd_o.out_load = (state_q == S_RESP) && out_free;
    cmd_o.status   = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (func_i == FUNC_POP) begin
              if (flags_i.empty) begin
                status_q <= ST_UNDERFLOW;
                state_q  <= S_RESP;
              end else begin
                status_q <= ST_OK;
                state_q  <= S_LOAD;
              end
            end else begin
              status_q <= flags_i.full ? ST_OVERFLOW : ST_OK;
              state_q  <= S_RESP;
            end
          end
        end
        S_LOAD: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `ASSERT_PROP(a_load_after_pop, clk_i, rst_ni, (state_q == S_LOAD) |-> $past(cmd_o.pop))
  `ASSERT_PROP(a_valid_from_resp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_RESP))
  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, cmd_o.push && flags_i.full)
  `ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, cmd_o.pop && flags_i.empty)

endmodule

`default_nettype wire

### src/swrm_dp.sv
// ----------------------------------------------------------------------------
// swrm_dp
// Datapath of the running-max stack: stack pointer, cached top entry, the
// entry memory below the top, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_dp
  import swrm_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] value_i,
  input  cmd_t                     cmd_i,
  output flags_t                   flags_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] max_value_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     is_empty_o,
  output logic [1:0]               status_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  // Entries below the top; the top entry itself lives in registers.
  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rd_q;

  logic [CW-1:0]              sp_q;
  logic [CW-1:0]              sp_d;
  logic signed [DATA_W-1:0]   top_val_q;
  logic signed [DATA_W-1:0]   top_max_q;
  logic signed [DATA_W-1:0]   new_max;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       empty;

  logic signed [DATA_W-1:0]   out_top_q;
  logic signed [DATA_W-1:0]   out_max_q;
  logic [COUNT_W-1:0]         out_count_q;
  logic                       out_empty_q;
  logic [1:0]                 out_status_q;

  assign empty         = (sp_q == '0);
  assign flags_o.empty = empty;
  assign flags_o.full  = (sp_q == CW'(DEPTH));

  assign wr_addr = AW'(sp_q - CW'(1));
  assign rd_addr = AW'(sp_q - CW'(2));

  assign new_max = (!empty && (top_max_q > value_i)) ? top_max_q : value_i;

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q + CW'(1);
    end else if (cmd_i.pop) begin
      sp_d = sp_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // The old top moves into memory on a push; a pop prefetches the entry
  // that becomes the new top.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !empty) begin
      mem[wr_addr] <= {top_max_q, top_val_q};
    end
    if (cmd_i.pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_val_q <= value_i;
      top_max_q <= new_max;
    end else if (cmd_i.load_top) begin
      top_val_q <= rd_q[DATA_W-1:0];
      top_max_q <= rd_q[2*DATA_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_top_q    <= empty ? '0 : top_val_q;
      out_max_q    <= empty ? '0 : top_max_q;
      out_count_q  <= COUNT_W'(sp_q);
      out_empty_q  <= empty;
      out_status_q <= cmd_i.status;
    end
  end

  assign top_value_o   = out_top_q;
  assign max_value_o   = out_max_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

### src/stack_with_running_max_top.sv
// ----------------------------------------------------------------------------
// stack_with_running_max_top
// LIFO stack of signed 32-bit values that also reports the maximum of all
// values it holds, with push and pop requests on a valid/stall channel.
// ----------------------------------------------------------------------------
// Each accepted word is a push (func 0) or a pop (func 1) and produces one
// result word with the top value, the running maximum, the entry count, an
// empty flag and a status code (ok, overflow on a push to a full stack,
// underflow on a pop from an empty one; a refused request leaves the stack
// unchanged). Top value and maximum read as zero when the stack is empty.
// The top entry is cached in registers and the entries below it sit in a
// single-port memory of DEPTH words, each holding a value and the running
// maximum at the time it was pushed. The result of a push or a refused
// request is loaded into the output register from the response state, and
// that of a successful pop passes a load state first, since the entry that
// becomes the new top must first be read from the memory. One word is
// handled at a time; the result sits in an output register and a new
// request is taken once it has been loaded there, even while it still
// waits to be taken. The stack is usable directly after reset: no memory
// clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_running_max_top
  import swrm_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Request channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] value_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] max_value_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     is_empty_o,
  output logic [1:0]               status_o
);

  cmd_t   cmd;
  flags_t flags;

  // The controller sequences each request and drives both handshakes.
  swrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .flags_i     (flags),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // The datapath holds the stack itself and the result register.
  swrm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .top_value_o   (top_value_o),
    .max_value_o   (max_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

### test/tb_stack_with_running_max_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_with_running_max_top
// Self-checking bench for the running-max stack: queued push and pop words
// are checked against a behavioral stack with random idling on both sides.
// ----------------------------------------------------------------------------
// An initial block fills a queue of request words. It starts with a short
// directed run and then adds random runs that fill the stack past full,
// drain it past empty, or mix pushes and pops. A clocked driver takes words
// from that queue. Each word accepted on the request channel goes through a
// behavioral copy of the stack, and the result word that it predicts is
// queued. A clocked monitor compares each accepted result word field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_stack_with_running_max_top;
  import swrm_pkg::*;

  localparam int STACK_DEPTH    = DEFAULT_DEPTH;
  localparam int RANDOM_WORDS   = 550;
  localparam int IDLE_PERCENT   = 24;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int REPORT_LIMIT   = 10;

  // One request word as it is queued for the driver.
  typedef struct {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } stack_word_t;

  // One result word as the block should report it.
  typedef struct {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] max;
    logic [COUNT_W-1:0]       count;
    logic                     empty;
    status_e                  status;
  } stack_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     func_i = FUNC_PUSH;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] top_value_o;
  logic signed [DATA_W-1:0] max_value_o;
  logic [COUNT_W-1:0]       entry_count_o;
  logic                     is_empty_o;
  logic [1:0]               status_o;

  stack_word_t   request_words[$];
  stack_result_t pending_results[$];

  // Behavioral stack: value and running maximum per entry, plus fill level.
  logic signed [DATA_W-1:0] held_value [STACK_DEPTH];
  logic signed [DATA_W-1:0] held_max [STACK_DEPTH];
  int unsigned              held_count = 0;

  // Fill level as the stimulus generator sees it, used to shape the runs.
  int unsigned planned_count = 0;

  int unsigned words_sent = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  stack_with_running_max_top #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o),
    .max_value_o  (max_value_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction and checking helpers
  // --------------------------------------------------------------------------

  // Applies one accepted request word to the behavioral stack and queues the
  // result word that it should produce. A refused push or pop leaves the
  // stack as it was; an empty stack reports zero for top and maximum.
  task automatic apply_stack_op(input logic func, input logic signed [DATA_W-1:0] value);
    stack_result_t            res;
    logic signed [DATA_W-1:0] running_max;
    res.status = ST_OK;
    if (func == FUNC_PUSH) begin
      if (held_count >= STACK_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        running_max = value;
        if (held_count > 0 && held_max[held_count-1] > running_max) begin
          running_max = held_max[held_count-1];
        end
        held_value[held_count] = value;
        held_max[held_count]   = running_max;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        held_count--;
      end
    end
    res.top   = (held_count > 0) ? held_value[held_count-1] : '0;
    res.max   = (held_count > 0) ? held_max[held_count-1] : '0;
    res.count = held_count[COUNT_W-1:0];
    res.empty = (held_count == 0);
    pending_results.push_back(res);
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      report_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    end
  endtask

  // The middle part of the run goes without any idling on either side.
  function automatic bit steady_stretch();
    return words_sent >= 200 && words_sent < 330;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the next queued word once the current one is taken, and
  // otherwise holds valid and payload steady. Prediction happens here, at
  // the edge where the word is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    stack_word_t next_word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i     <= FUNC_PUSH;
      value_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_stack_op(func_i, value_i);
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_words.size() != 0 &&
            (steady_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_word  = request_words.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= next_word.func;
          value_i    <= next_word.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every accepted result word against the oldest prediction
  // and stalls the result channel at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    stack_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_failure("result word arrived with no prediction waiting");
        end else begin
          want = pending_results.pop_front();
          check_field("top_value", want.top, top_value_o);
          check_field("max_value", want.max, max_value_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("is_empty", want.empty, is_empty_o);
          check_field("status", want.status, status_o);
        end
      end
      out_stall_i <= !steady_stretch() && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run of cycles with no word moving on either channel means
  // the block has hung.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queues one request word and tracks the fill level it will leave.
  task automatic queue_word(input logic func, input logic signed [DATA_W-1:0] value);
    stack_word_t w;
    w.func  = func;
    w.value = value;
    request_words.push_back(w);
    if (func == FUNC_PUSH && planned_count < STACK_DEPTH) begin
      planned_count++;
    end else if (func == FUNC_POP && planned_count > 0) begin
      planned_count--;
    end
  endtask

  // Value patterns for pushes: full range, a narrow band around zero so that
  // equal values meet, rising and falling ramps, and the extremes, zero and -1.
  function automatic logic signed [DATA_W-1:0] pick_value(input int pattern, input int idx);
    case (pattern)
      0: return $urandom;
      1: return int'($urandom_range(0, 40)) - 20;
      2: return -1000 + idx * 37;
      3: return 1000 - idx * 37;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Holds the sender back until every queued word has been taken and every
  // predicted result word has come back.
  task automatic wait_until_drained();
    do begin
      @(negedge clk_i);
    end while (request_words.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  initial begin : stimulus
    int  random_words;
    int  run_len;
    int  kind;
    int  pattern;
    bit  paused;
    random_words = 0;
    paused       = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed run. A pop on the empty stack must be refused, the extremes
    // must order correctly as signed values, a smaller push must not lower
    // the maximum, and pops must restore each earlier maximum.
    queue_word(FUNC_POP, 32'sh1234_5678);
    queue_word(FUNC_PUSH, 32'sh7FFF_FFFF);
    queue_word(FUNC_PUSH, 32'sh8000_0000);
    queue_word(FUNC_PUSH, '0);
    queue_word(FUNC_PUSH, -1);
    queue_word(FUNC_POP, -1);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, 32'sh7FFF_FFFF);
    queue_word(FUNC_POP, 32'sh8000_0000);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_PUSH, 32'sh8000_0000);
    queue_word(FUNC_PUSH, -5);
    queue_word(FUNC_PUSH, 32'sh7FFF_FFFF);
    queue_word(FUNC_PUSH, 32'sh5555_5555);
    queue_word(FUNC_PUSH, 32'shAAAA_AAAA);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, '0);
    queue_word(FUNC_POP, 32'shFFFF_FFFF);
    wait_until_drained();

    // Random runs. Fill runs push past full so that overflow is refused,
    // drain runs pop past empty, and mixed runs wander in between.
    while (random_words < RANDOM_WORDS) begin
      if (!paused && random_words >= RANDOM_WORDS / 2) begin
        wait_until_drained();
        paused = 1'b1;
      end
      kind    = $urandom_range(0, 9);
      pattern = $urandom_range(0, 4);
      if (kind < 2) begin
        run_len = STACK_DEPTH - planned_count + $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) begin
          queue_word(FUNC_PUSH, pick_value(pattern, i));
        end
      end else if (kind < 4) begin
        run_len = planned_count + $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) begin
          queue_word(FUNC_POP, $urandom);
        end
      end else begin
        run_len = $urandom_range(5, 30);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 99) < 55) begin
            queue_word(FUNC_PUSH, pick_value(pattern, i));
          end else begin
            queue_word(FUNC_POP, $urandom);
          end
        end
      end
      random_words += run_len;
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
